@@ hdl/cam_pkg.sv @@
`default_nettype none
package cam_pkg;

    typedef struct packed {
        logic [31:0] arc_begin;
        logic [31:0] arc_finish;
        logic        last_arc;
    } arc_in_t;

    typedef struct packed {
        logic [10:0] max_count;
        logic        no_point;
    } arc_out_t;

    localparam int STW = 6;

    localparam logic [STW-1:0] ST_IDLE  = 6'd0;
    localparam logic [STW-1:0] ST_MRD   = 6'd1;
    localparam logic [STW-1:0] ST_MINIT = 6'd2;
    localparam logic [STW-1:0] ST_MSTEP = 6'd3;
    localparam logic [STW-1:0] ST_MWR   = 6'd4;
    localparam logic [STW-1:0] ST_SI    = 6'd5;
    localparam logic [STW-1:0] ST_SK    = 6'd6;
    localparam logic [STW-1:0] ST_SR    = 6'd7;
    localparam logic [STW-1:0] ST_SL    = 6'd8;
    localparam logic [STW-1:0] ST_SC    = 6'd9;
    localparam logic [STW-1:0] ST_SPUT  = 6'd10;
    localparam logic [STW-1:0] ST_DR    = 6'd11;
    localparam logic [STW-1:0] ST_DW    = 6'd12;
    localparam logic [STW-1:0] ST_PR    = 6'd13;
    localparam logic [STW-1:0] ST_PP    = 6'd14;
    localparam logic [STW-1:0] ST_CR    = 6'd15;
    localparam logic [STW-1:0] ST_CC    = 6'd16;
    localparam logic [STW-1:0] ST_PN    = 6'd17;
    localparam logic [STW-1:0] ST_KR    = 6'd18;
    localparam logic [STW-1:0] ST_KA    = 6'd19;
    localparam logic [STW-1:0] ST_KB    = 6'd20;
    localparam logic [STW-1:0] ST_G0    = 6'd21;
    localparam logic [STW-1:0] ST_GAR   = 6'd22;
    localparam logic [STW-1:0] ST_GAE   = 6'd23;
    localparam logic [STW-1:0] ST_GAF   = 6'd24;
    localparam logic [STW-1:0] ST_GB0   = 6'd25;
    localparam logic [STW-1:0] ST_GB1   = 6'd26;
    localparam logic [STW-1:0] ST_GB2   = 6'd27;
    localparam logic [STW-1:0] ST_GBR   = 6'd28;
    localparam logic [STW-1:0] ST_GBE   = 6'd29;
    localparam logic [STW-1:0] ST_GBU   = 6'd30;
    localparam logic [STW-1:0] ST_GRET  = 6'd31;
    localparam logic [STW-1:0] ST_OUT   = 6'd32;

    typedef struct packed {
        logic [STW-1:0] op;
        logic           load;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic i_last;
        logic j_zero;
        logic stop;
        logic n_one;
        logic fail;
        logic scan_last;
        logic k_done;
        logic found;
        logic brk;
        logic gi_last;
        logic g_excl;
    } sts_t;

    // inclusive length from lo to hi going forward around a circle of m
    function automatic logic [32:0] arc_len(input logic [31:0] lo, input logic [31:0] hi,
                                            input logic [32:0] m);
        logic [32:0] r;
        if (hi >= lo)
            r = {1'b0, hi} - {1'b0, lo} + 33'd1;
        else
            r = m - {1'b0, lo} + {1'b0, hi} + 33'd1;
        return r;
    endfunction

    function automatic logic arc_covers(input logic [31:0] s, input logic [31:0] e,
                                        input logic [31:0] p);
        logic r;
        if (s <= e)
            r = (p >= s) && (p <= e);
        else
            r = (p >= s) || (p <= e);
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/circular_arc_max_disjoint_top.sv @@
`default_nettype none
// channel   signals                        direction  accepted when
// arc in    start, busy, arc               in         start && !busy
// result    done, result                   out        done (one cycle)
// config    cfg_valid, cfg_ready, cfg_data in         cfg_valid && cfg_ready
//
// An arc not marked last is taken while busy is low; arcs stream at one per cycle while idle.
// The last arc starts the set: a modulo reduction of each arc, an insertion sort, a
// dedupe pass, a scan per candidate point and up to MAX_COVER+1 greedy runs.
// Reset clears the controller and the arc count; memories need no clearing.
// The result is shown for one cycle on done; the receiver cannot stall it.
module circular_arc_max_disjoint_top #(
    parameter int MAX_ARCS  = 1024,
    parameter int MAX_COVER = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire cam_pkg::arc_in_t  arc,
    output logic                   done,
    output cam_pkg::arc_out_t      result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [31:0]       cfg_data
);
    import cam_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    cam_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last_arc (arc.last_arc),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    cam_dp #(
        .MAX_ARCS  (MAX_ARCS),
        .MAX_COVER (MAX_COVER)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .arc       (arc),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .done      (done),
        .result    (result)
    );

endmodule
`default_nettype wire

@@ hdl/cam_ctrl.sv @@
`default_nettype none
module cam_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          last_arc,
    input  wire cam_pkg::sts_t sts,
    output cam_pkg::cmd_t      cmd,
    output logic               busy
);
    import cam_pkg::*;

    logic [STW-1:0] state_reg;
    logic [STW-1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (start && last_arc) state_next = ST_MRD;
            ST_MRD:   state_next = ST_MINIT;
            ST_MINIT: state_next = ST_MSTEP;
            ST_MSTEP: if (sts.div_last) state_next = ST_MWR;
            ST_MWR:   state_next = sts.i_last ? ST_SI : ST_MRD;
            ST_SI:    state_next = ST_SK;
            ST_SK:    state_next = ST_SR;
            ST_SR:    state_next = sts.j_zero ? ST_SPUT : ST_SL;
            ST_SL:    state_next = ST_SC;
            ST_SC:    state_next = sts.stop ? ST_SPUT : ST_SR;
            ST_SPUT:  state_next = sts.i_last ? ST_DR : ST_SI;
            ST_DR:    state_next = ST_DW;
            ST_DW:    state_next = sts.i_last ? ST_PR : ST_DR;
            ST_PR:    state_next = ST_PP;
            ST_PP:    state_next = sts.n_one ? ST_KR : ST_CR;
            ST_CR:    state_next = ST_CC;
            ST_CC:
            begin
                if (sts.fail)
                    state_next = ST_PN;
                else if (sts.scan_last)
                    state_next = ST_KR;
                else
                    state_next = ST_CR;
            end
            ST_PN:    state_next = sts.i_last ? ST_OUT : ST_PR;
            ST_KR:    state_next = sts.k_done ? ST_G0 : ST_KA;
            ST_KA:    state_next = ST_KB;
            ST_KB:    state_next = ST_G0;
            ST_G0:    state_next = ST_GAR;
            ST_GAR:   state_next = ST_GAE;
            ST_GAE:   state_next = ST_GAF;
            ST_GAF:   state_next = sts.gi_last ? ST_GB0 : ST_GAR;
            ST_GB0:   state_next = sts.found ? ST_GB1 : ST_GRET;
            ST_GB1:   state_next = ST_GB2;
            ST_GB2:   state_next = sts.n_one ? ST_GRET : ST_GBR;
            ST_GBR:   state_next = ST_GBE;
            ST_GBE:   state_next = ST_GBU;
            ST_GBU:   state_next = (sts.brk || sts.gi_last) ? ST_GRET : ST_GBR;
            ST_GRET:  state_next = sts.g_excl ? ST_OUT : ST_KR;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign cmd.op   = state_reg;
    assign cmd.load = start && (state_reg == ST_IDLE);

endmodule
`default_nettype wire

@@ hdl/cam_dp.sv @@
`default_nettype none
module cam_dp #(
    parameter int MAX_ARCS  = 1024,
    parameter int MAX_COVER = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cam_pkg::cmd_t     cmd,
    input  wire cam_pkg::arc_in_t  arc,
    input  wire logic              cfg_valid,
    input  wire logic [31:0]       cfg_data,
    output cam_pkg::sts_t          sts,
    output logic                   done,
    output cam_pkg::arc_out_t      result
);
    import cam_pkg::*;

    localparam int AW = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
    localparam int CW = $clog2(MAX_ARCS + 1);
    localparam int KW = $clog2(MAX_COVER + 1);
    localparam int KA = (MAX_COVER > 1) ? $clog2(MAX_COVER) : 1;
    localparam logic [CW-1:0] N_MAX = CW'(MAX_ARCS);
    localparam logic [KW-1:0] K_MAX = KW'(MAX_COVER);

    logic [63:0]    arc_mem  [MAX_ARCS];
    logic           excl_mem [MAX_ARCS];
    logic [AW-1:0]  cov_mem  [MAX_COVER];

    logic [31:0]    cs_reg;
    logic [CW-1:0]  tot_reg;
    logic           done_reg;
    arc_out_t       res_reg;

    logic [63:0]    rd_arc_reg;
    logic           rd_excl_reg;
    logic [AW-1:0]  cov_rd_reg;

    logic [AW-1:0]  i_reg, j_reg, o_reg;
    logic [CW-1:0]  w_reg;
    logic [KW-1:0]  k_reg, cnt_reg;
    logic [4:0]     dcnt_reg;
    logic [31:0]    xb_reg, xf_reg, rb_reg, rf_reg;
    logic [31:0]    key_b_reg, key_e_reg, lastf_reg, p_reg;
    logic [32:0]    key_len_reg, plen_reg;
    logic [31:0]    g_from_reg, us_reg, ue_reg, e_reg;
    logic           g_excl_reg, found_reg, skip_reg, cond_reg;
    logic [32:0]    best_d_reg, d_reg, size_reg, ns_reg;
    logic [AW-1:0]  first_reg, gi_reg, gidx_reg;
    logic [CW-1:0]  gcount_reg, best_reg;

    logic [32:0]    circ_len;
    logic [31:0]    rd_b, rd_f;
    logic           i_last, gi_last, hit, keep;
    logic [32:0]    tb, tf, f1;
    logic [CW-1:0]  best_new;
    logic [31:0]    best_wide;

    logic           mem_we, mem_re, ex_we, ex_wd, cov_we, cov_re;
    logic [AW-1:0]  mem_wa, mem_ra, ex_wa;
    logic [63:0]    mem_wd;

    assign circ_len = (cs_reg == 32'd0) ? 33'h1_0000_0000 : {1'b0, cs_reg};
    assign rd_b     = rd_arc_reg[63:32];
    assign rd_f     = rd_arc_reg[31:0];
    assign i_last   = (CW'(i_reg) + CW'(1)) == tot_reg;
    assign gi_last  = (CW'(gi_reg) + CW'(1)) == tot_reg;
    assign hit      = arc_covers(rd_b, rd_f, p_reg);
    assign keep     = (w_reg == '0) || (rd_f != lastf_reg);
    assign tb       = {rb_reg, xb_reg[31]};
    assign tf       = {rf_reg, xf_reg[31]};
    assign f1       = {1'b0, rd_f} + 33'd1;
    assign best_new = (gcount_reg > best_reg) ? gcount_reg : best_reg;
    assign best_wide = 32'(best_new);

    always_comb
    begin
        sts.div_last  = (dcnt_reg == 5'd31);
        sts.i_last    = i_last;
        sts.j_zero    = (j_reg == '0);
        sts.stop      = (rd_f < key_e_reg) || ((rd_f == key_e_reg) && (plen_reg <= key_len_reg));
        sts.n_one     = (tot_reg == CW'(1));
        sts.fail      = hit && (cnt_reg == K_MAX);
        sts.scan_last = (CW'(j_reg) + CW'(2)) == tot_reg;
        sts.k_done    = (k_reg == cnt_reg);
        sts.found     = found_reg;
        sts.brk       = !skip_reg && cond_reg && (ns_reg < size_reg);
        sts.gi_last   = gi_last;
        sts.g_excl    = g_excl_reg;
    end

    // memory port steering
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = i_reg;
        mem_wd = rd_arc_reg;
        mem_re = 1'b0;
        mem_ra = i_reg;
        ex_we  = 1'b0;
        ex_wa  = i_reg;
        ex_wd  = 1'b0;
        cov_we = 1'b0;
        cov_re = 1'b0;
        case (cmd.op)
            ST_IDLE:
            begin
                mem_we = cmd.load && (tot_reg < N_MAX);
                mem_wa = tot_reg[AW-1:0];
                mem_wd = {arc.arc_begin, arc.arc_finish};
            end
            ST_MRD, ST_SI, ST_DR, ST_PR: mem_re = 1'b1;
            ST_MWR:
            begin
                mem_we = 1'b1;
                mem_wd = {rb_reg, rf_reg};
            end
            ST_SR:
            begin
                mem_re = 1'b1;
                mem_ra = j_reg - AW'(1);
            end
            ST_SC:
            begin
                mem_we = !sts.stop;
                mem_wa = j_reg;
            end
            ST_SPUT:
            begin
                mem_we = 1'b1;
                mem_wa = j_reg;
                mem_wd = {key_b_reg, key_e_reg};
            end
            ST_DW:
            begin
                mem_we = keep;
                mem_wa = w_reg[AW-1:0];
            end
            ST_CR:
            begin
                mem_re = 1'b1;
                mem_ra = o_reg;
            end
            ST_CC:   cov_we = hit && (cnt_reg != K_MAX);
            ST_KR:   cov_re = !sts.k_done;
            ST_KA:
            begin
                mem_re = 1'b1;
                mem_ra = cov_rd_reg;
            end
            ST_GAR:
            begin
                mem_re = 1'b1;
                mem_ra = gi_reg;
            end
            ST_GB0:
            begin
                mem_re = found_reg;
                mem_ra = first_reg;
            end
            ST_GBR:
            begin
                mem_re = 1'b1;
                mem_ra = gidx_reg;
            end
            default: mem_we = 1'b0;
        endcase
        // every arc write clears the exclusion mark; covers set it
        if (mem_we)
        begin
            ex_we = 1'b1;
            ex_wa = mem_wa;
        end
        if (cmd.op == ST_KA)
        begin
            ex_we = 1'b1;
            ex_wa = cov_rd_reg;
            ex_wd = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            arc_mem[mem_wa] <= mem_wd;
        if (ex_we)
            excl_mem[ex_wa] <= ex_wd;
        if (mem_re)
        begin
            rd_arc_reg  <= arc_mem[mem_ra];
            rd_excl_reg <= excl_mem[mem_ra];
        end
        if (cov_we)
            cov_mem[cnt_reg[KA-1:0]] <= o_reg;
        if (cov_re)
            cov_rd_reg <= cov_mem[k_reg[KA-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg   <= 32'hFFFF_FFFF;
            tot_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op == ST_OUT);
            if (cfg_valid)
                cs_reg <= cfg_data;
            if (cmd.load && (tot_reg < N_MAX))
                tot_reg <= tot_reg + CW'(1);
            if ((cmd.op == ST_DW) && i_last)
                tot_reg <= keep ? (w_reg + CW'(1)) : w_reg;
            if (cmd.op == ST_OUT)
                tot_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ST_IDLE:
                if (cmd.load)
                    i_reg <= '0;
            ST_MINIT:
            begin
                xb_reg   <= rd_b;
                xf_reg   <= rd_f;
                rb_reg   <= '0;
                rf_reg   <= '0;
                dcnt_reg <= '0;
            end
            ST_MSTEP:
            begin
                // one quotient bit per cycle for each end
                rb_reg   <= (tb >= circ_len) ? 32'(tb - circ_len) : tb[31:0];
                rf_reg   <= (tf >= circ_len) ? 32'(tf - circ_len) : tf[31:0];
                xb_reg   <= {xb_reg[30:0], 1'b0};
                xf_reg   <= {xf_reg[30:0], 1'b0};
                dcnt_reg <= dcnt_reg + 5'd1;
            end
            ST_MWR:  i_reg <= i_last ? '0 : i_reg + AW'(1);
            ST_SK:
            begin
                key_b_reg   <= rd_b;
                key_e_reg   <= rd_f;
                key_len_reg <= arc_len(rd_b, rd_f, circ_len);
                j_reg       <= i_reg;
            end
            ST_SL:   plen_reg <= arc_len(rd_b, rd_f, circ_len);
            ST_SC:
                if (!sts.stop)
                    j_reg <= j_reg - AW'(1);
            ST_SPUT:
            begin
                i_reg <= i_last ? '0 : i_reg + AW'(1);
                w_reg <= '0;
            end
            ST_DW:
            begin
                if (keep)
                begin
                    lastf_reg <= rd_f;
                    w_reg     <= w_reg + CW'(1);
                end
                i_reg <= i_last ? '0 : i_reg + AW'(1);
            end
            ST_PP:
            begin
                p_reg      <= (f1 == circ_len) ? 32'd0 : f1[31:0];
                o_reg      <= i_last ? '0 : i_reg + AW'(1);
                j_reg      <= '0;
                cnt_reg    <= '0;
                k_reg      <= '0;
                best_reg   <= '0;
            end
            ST_CC:
            begin
                if (hit && (cnt_reg != K_MAX))
                    cnt_reg <= cnt_reg + KW'(1);
                j_reg <= j_reg + AW'(1);
                o_reg <= ((CW'(o_reg) + CW'(1)) == tot_reg) ? '0 : o_reg + AW'(1);
            end
            ST_PN:
            begin
                i_reg   <= i_reg + AW'(1);
                res_reg <= '{max_count: 11'd0, no_point: 1'b1};
            end
            ST_KR:
                if (sts.k_done)
                begin
                    g_from_reg <= p_reg;
                    g_excl_reg <= 1'b1;
                end
            ST_KB:
            begin
                g_from_reg <= rd_f;
                g_excl_reg <= 1'b0;
            end
            ST_G0:
            begin
                gi_reg    <= '0;
                found_reg <= 1'b0;
            end
            ST_GAE:
            begin
                skip_reg <= g_excl_reg && rd_excl_reg;
                d_reg    <= arc_len(g_from_reg, rd_f, circ_len);
            end
            ST_GAF:
            begin
                if (!skip_reg && (!found_reg || (d_reg < best_d_reg)))
                begin
                    found_reg  <= 1'b1;
                    best_d_reg <= d_reg;
                    first_reg  <= gi_reg;
                end
                gi_reg <= gi_reg + AW'(1);
            end
            ST_GB0:
                if (!found_reg)
                    gcount_reg <= '0;
            ST_GB1:
            begin
                us_reg     <= rd_b;
                ue_reg     <= rd_f;
                gcount_reg <= CW'(1);
            end
            ST_GB2:
            begin
                size_reg <= arc_len(us_reg, ue_reg, circ_len);
                gi_reg   <= AW'(1);
                gidx_reg <= ((CW'(first_reg) + CW'(1)) == tot_reg) ? '0
                                                                 : first_reg + AW'(1);
            end
            ST_GBE:
            begin
                skip_reg <= g_excl_reg && rd_excl_reg;
                cond_reg <= !arc_covers(us_reg, ue_reg, rd_b)
                         && !arc_covers(us_reg, ue_reg, rd_f)
                         && !arc_covers(rd_b, rd_f, us_reg);
                ns_reg   <= arc_len(us_reg, rd_f, circ_len);
                e_reg    <= rd_f;
            end
            ST_GBU:
            begin
                if (!skip_reg && cond_reg && !(ns_reg < size_reg))
                begin
                    ue_reg     <= e_reg;
                    size_reg   <= ns_reg;
                    gcount_reg <= gcount_reg + CW'(1);
                end
                gi_reg   <= gi_reg + AW'(1);
                gidx_reg <= ((CW'(gidx_reg) + CW'(1)) == tot_reg) ? '0
                                                                : gidx_reg + AW'(1);
            end
            ST_GRET:
            begin
                best_reg <= best_new;
                k_reg    <= k_reg + KW'(1);
                if (g_excl_reg)
                begin
                    res_reg.max_count <= (best_wide > 32'd2047) ? 11'h7FF : best_wide[10:0];
                    res_reg.no_point  <= 1'b0;
                end
            end
            default: dcnt_reg <= dcnt_reg;
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire
